### rtl/core/ubx_ack_pkg.sv
// Shared types and protocol constants for the acknowledgement frame parser.
package ubx_ack_pkg;

    // Frame sync and field values
    localparam logic [7:0] SYNC_CHAR_1  = 8'hB5;
    localparam logic [7:0] SYNC_CHAR_2  = 8'h62;
    localparam logic [7:0] CLASS_ACK    = 8'h05;
    localparam logic [7:0] ID_ACK       = 8'h01;
    localparam logic [7:0] LEN_ACK_LO   = 8'h02;
    localparam logic [7:0] LEN_ACK_HI   = 8'h00;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int TICK_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Input kinds carried on s_tuser
    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    // Parser phases
    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } phase_t;

    // Reported outcome codes
    typedef enum logic [1:0] {
        OUT_ACK     = 2'd0,
        OUT_NAK     = 2'd1,
        OUT_TIMEOUT = 2'd2
    } outcome_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXP_CLASS = 2'd0,
        CFG_EXP_ID    = 2'd1,
        CFG_TIMEOUT   = 2'd2
    } cfg_index_t;

    // Result handed from the parser to the output stage
    typedef struct packed {
        logic     valid;
        outcome_t outcome;
    } parse_result_t;

endpackage

### rtl/core/ubx_ack_parser.sv
// Frame parser, Fletcher checksum and tick timeout for one byte or tick per cycle.
module ubx_ack_parser
    import ubx_ack_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,           // an input transfer happens this cycle
    input  logic                action,         // ACTION_BYTE or ACTION_TICK
    input  logic [BYTE_W-1:0]   rx_byte,
    input  logic [BYTE_W-1:0]   expected_class,
    input  logic [BYTE_W-1:0]   expected_id,
    input  logic [TICK_W-1:0]   timeout_ticks,
    output parse_result_t       result
);

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   class_reg, class_next;
    logic [BYTE_W-1:0]   id_reg, id_next;
    logic [BYTE_W-1:0]   len_lo_reg, len_lo_next;
    logic [BYTE_W-1:0]   payload_reg [2];
    logic                payload_cnt_reg, payload_cnt_next;
    logic                payload_we;
    logic [BYTE_W-1:0]   sum_a_reg, sum_a_next;
    logic [BYTE_W-1:0]   sum_b_reg, sum_b_next;
    logic [BYTE_W-1:0]   ck_a_reg, ck_a_next;
    logic [TICK_W-1:0]   tick_cnt_reg, tick_cnt_next;

    logic [BYTE_W-1:0]   sum_a_add;
    logic [BYTE_W-1:0]   sum_b_add;
    logic [TICK_W-1:0]   tick_inc;
    logic                frame_ok;

    // Running Fletcher sums with the current byte
    assign sum_a_add = sum_a_reg + rx_byte;
    assign sum_b_add = sum_b_reg + sum_a_add;

    // Saturating tick increment
    assign tick_inc = (tick_cnt_reg == {TICK_W{1'b1}}) ? tick_cnt_reg
                                                      : tick_cnt_reg + 1'b1;

    // Checksum, class and payload match on the last check byte
    assign frame_ok = (sum_a_reg == ck_a_reg) && (sum_b_reg == rx_byte) &&
                      (class_reg == CLASS_ACK) &&
                      (payload_reg[0] == expected_class) &&
                      (payload_reg[1] == expected_id);

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_SYNC1;
            class_reg       <= '0;
            id_reg          <= '0;
            len_lo_reg      <= '0;
            payload_cnt_reg <= 1'b0;
            sum_a_reg       <= '0;
            sum_b_reg       <= '0;
            ck_a_reg        <= '0;
            tick_cnt_reg    <= '0;
        end else begin
            phase_reg       <= phase_next;
            class_reg       <= class_next;
            id_reg          <= id_next;
            len_lo_reg      <= len_lo_next;
            payload_cnt_reg <= payload_cnt_next;
            sum_a_reg       <= sum_a_next;
            sum_b_reg       <= sum_b_next;
            ck_a_reg        <= ck_a_next;
            tick_cnt_reg    <= tick_cnt_next;
        end
    end

    // Payload bytes, no reset needed: always written before the check bytes
    always_ff @(posedge aclk) begin
        if (payload_we) begin
            payload_reg[payload_cnt_reg] <= rx_byte;
        end
    end

    // Next state and result
    always_comb begin
        phase_next       = phase_reg;
        class_next       = class_reg;
        id_next          = id_reg;
        len_lo_next      = len_lo_reg;
        payload_cnt_next = payload_cnt_reg;
        payload_we       = 1'b0;
        sum_a_next       = sum_a_reg;
        sum_b_next       = sum_b_reg;
        ck_a_next        = ck_a_reg;
        tick_cnt_next    = tick_cnt_reg;
        result.valid     = 1'b0;
        result.outcome   = OUT_TIMEOUT;

        if (step) begin
            if (action == ACTION_TICK) begin
                tick_cnt_next = tick_inc;
                if (tick_inc >= timeout_ticks) begin
                    result.valid   = 1'b1;
                    result.outcome = OUT_TIMEOUT;
                    phase_next     = PH_SYNC1;
                    tick_cnt_next  = '0;
                end
            end else begin
                unique case (phase_reg)
                    PH_SYNC2: begin
                        phase_next = (rx_byte == SYNC_CHAR_2) ? PH_CLASS : PH_SYNC1;
                    end
                    PH_CLASS: begin
                        class_next = rx_byte;
                        sum_a_next = rx_byte;
                        sum_b_next = rx_byte;
                        phase_next = PH_ID;
                    end
                    PH_ID: begin
                        id_next    = rx_byte;
                        sum_a_next = sum_a_add;
                        sum_b_next = sum_b_add;
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        len_lo_next = rx_byte;
                        sum_a_next  = sum_a_add;
                        sum_b_next  = sum_b_add;
                        phase_next  = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        sum_a_next       = sum_a_add;
                        sum_b_next       = sum_b_add;
                        payload_cnt_next = 1'b0;
                        phase_next = (len_lo_reg == LEN_ACK_LO && rx_byte == LEN_ACK_HI)
                                   ? PH_PAYLOAD : PH_SYNC1;
                    end
                    PH_PAYLOAD: begin
                        payload_we       = 1'b1;
                        sum_a_next       = sum_a_add;
                        sum_b_next       = sum_b_add;
                        payload_cnt_next = ~payload_cnt_reg;
                        if (payload_cnt_reg) begin
                            phase_next = PH_CK_A;
                        end
                    end
                    PH_CK_A: begin
                        ck_a_next  = rx_byte;
                        phase_next = PH_CK_B;
                    end
                    PH_CK_B: begin
                        phase_next = PH_SYNC1;
                        if (frame_ok) begin
                            result.valid   = 1'b1;
                            result.outcome = (id_reg == ID_ACK) ? OUT_ACK : OUT_NAK;
                            tick_cnt_next  = '0;
                        end
                    end
                    // first sync byte, and any phase code without meaning
                    default: begin
                        phase_next = (rx_byte == SYNC_CHAR_1) ? PH_SYNC2 : PH_SYNC1;
                    end
                endcase
            end
        end
    end

    // A byte only reports from the last check byte
    a_byte_report_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (result.valid && action == ACTION_BYTE) |-> (phase_reg == PH_CK_B))
        else $error("byte report outside check phase");

    // A timeout only comes from a tick
    a_timeout_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (result.valid && result.outcome == OUT_TIMEOUT) |-> (action == ACTION_TICK))
        else $error("timeout reported on a byte");

    // Any report restarts hunting with a cleared tick count
    a_restart_after_report: assert property (@(posedge aclk) disable iff (!aresetn)
        result.valid |=> (phase_reg == PH_SYNC1 && tick_cnt_reg == '0))
        else $error("parser did not restart after report");

    // Ticks without a report never lower the count
    a_tick_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && action == ACTION_TICK && !result.valid)
            |=> (tick_cnt_reg >= $past(tick_cnt_reg)))
        else $error("tick count went down");

endmodule

### rtl/core/ubx_ack_frame_parser.sv
// Top level: stream ports, configuration registers and result register of the ACK parser.
//
// Input stream (s_*): each transfer is one event. s_tuser[0] = 0 marks a received
// UART byte in s_tdata[7:0]; s_tuser[0] = 1 marks a one millisecond tick.
// Result stream (m_*): one transfer per report, m_tdata[1:0] = 0 ACK, 1 NAK,
// 2 timeout, upper bits zero.
// Configuration: cfg_addr selects 0 expected class, 1 expected id, 2 timeout in
// ticks; cfg_ready is always high, other addresses are dropped. Write only while
// no event is in flight.
// A report is on m_tvalid in the cycle after the transfer that caused it.
// Throughput: one event per cycle; the parser state and the Fletcher sums
// update with each accepted event, and the result register takes the next
// event in the same cycle that a waiting report is taken. s_tready drops only
// while a report is held and m_tready is low.
// Reset (aresetn low, synchronous): parser hunts for the first sync byte, tick
// count and sums clear, registers return to class 6, id 138, timeout 1000.
module ubx_ack_frame_parser
    import ubx_ack_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input events
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,     // [7:0] rx_byte
    input  logic [0:0]            s_tuser,     // [0] action
    // reports
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,     // [1:0] outcome, [7:2] zero
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [TICK_W-1:0]     cfg_wdata
);

    logic [BYTE_W-1:0] exp_class_reg;
    logic [BYTE_W-1:0] exp_id_reg;
    logic [TICK_W-1:0] timeout_reg;
    logic              m_valid_reg;
    outcome_t          m_outcome_reg;
    logic              s_accept;
    parse_result_t     result;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_class_reg <= 8'd6;
            exp_id_reg    <= 8'd138;
            timeout_reg   <= 16'd1000;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                CFG_EXP_CLASS: exp_class_reg <= cfg_wdata[BYTE_W-1:0];
                CFG_EXP_ID:    exp_id_reg    <= cfg_wdata[BYTE_W-1:0];
                CFG_TIMEOUT:   timeout_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    ubx_ack_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (s_accept),
        .action         (s_tuser[0]),
        .rx_byte        (s_tdata),
        .expected_class (exp_class_reg),
        .expected_id    (exp_id_reg),
        .timeout_ticks  (timeout_reg),
        .result         (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept && result.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && result.valid) begin
            m_outcome_reg <= result.outcome;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_outcome_reg};

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the acknowledgement frame parser: byte/tick stream in, reports out.
module tb_top;
    import ubx_ack_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // decoded by nothing
    localparam logic [7:0] ID_NAK_PLAIN = 8'h00;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } rx_event_t;

    typedef enum int {
        FR_GOOD,
        FR_BAD_SYNC2,
        FR_BAD_LEN_LO,
        FR_BAD_LEN_HI,
        FR_BAD_CK_A,
        FR_BAD_CK_B
    } frame_flaw_t;

    typedef enum int { RX_ALWAYS, RX_RANDOM, RX_BURSTY } rx_mode_t;

    // DUT ports
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;   // [7:0] rx_byte
    logic [0:0]           s_tuser   = '0;   // [0] action
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;          // [1:0] outcome, [7:2] zero
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [TICK_W-1:0]    cfg_wdata = '0;

    ubx_ack_frame_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow of the parser: registers, frame state, tick counter
    logic [7:0]  want_class = 8'd6;
    logic [7:0]  want_id    = 8'd138;
    logic [15:0] tick_limit = 16'd1000;
    phase_t      hunt_phase = PH_SYNC1;
    logic [7:0]  frm_class  = '0;
    logic [7:0]  frm_id     = '0;
    logic [7:0]  frm_len_lo = '0;
    logic [7:0]  frm_payload [2];
    logic        pay_idx    = 1'b0;
    logic [7:0]  fl_a       = '0;
    logic [7:0]  fl_b       = '0;
    logic [7:0]  chk_a_rx   = '0;
    logic [15:0] tick_cnt   = '0;

    outcome_t    outcome_q [$];     // reports still owed by the DUT
    rx_event_t   pending_q [$];     // events not yet offered
    outcome_t    head_outcome;
    rx_event_t   next_ev;

    int unsigned n_errors = 0;
    int unsigned n_queued = 0;
    int unsigned n_events = 0;
    int unsigned n_cfg_writes = 0;
    int unsigned n_ack = 0;
    int unsigned n_nak = 0;
    int unsigned n_timeout = 0;
    int unsigned cyc_count = 0;
    int          tick_noise_pct = 0;
    bit          sender_steady = 1'b0;
    bit          in_xfer = 1'b0;

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic fold_byte(input logic [7:0] b);
        fl_a = fl_a + b;
        fl_b = fl_b + fl_a;
    endtask

    // Advance the shadow parser by one accepted event
    task automatic predict_event(input rx_event_t ev);
        logic [7:0] b;
        b = ev.rx_byte;
        if (ev.action == ACTION_TICK) begin
            if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= tick_limit) begin
                outcome_q.push_back(OUT_TIMEOUT);
                hunt_phase = PH_SYNC1;
                tick_cnt   = '0;
            end
        end else begin
            case (hunt_phase)
                PH_SYNC2: begin
                    hunt_phase = (b == SYNC_CHAR_2) ? PH_CLASS : PH_SYNC1;
                end
                PH_CLASS: begin
                    frm_class  = b;
                    fl_a       = '0;
                    fl_b       = '0;
                    fold_byte(b);
                    hunt_phase = PH_ID;
                end
                PH_ID: begin
                    frm_id     = b;
                    fold_byte(b);
                    hunt_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    frm_len_lo = b;
                    fold_byte(b);
                    hunt_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    fold_byte(b);
                    pay_idx    = 1'b0;
                    hunt_phase = (frm_len_lo == LEN_ACK_LO && b == LEN_ACK_HI) ?
                                 PH_PAYLOAD : PH_SYNC1;
                end
                PH_PAYLOAD: begin
                    frm_payload[pay_idx] = b;
                    fold_byte(b);
                    if (pay_idx) begin
                        pay_idx    = 1'b0;
                        hunt_phase = PH_CK_A;
                    end else begin
                        pay_idx = 1'b1;
                    end
                end
                PH_CK_A: begin
                    chk_a_rx   = b;
                    hunt_phase = PH_CK_B;
                end
                PH_CK_B: begin
                    hunt_phase = PH_SYNC1;
                    if (fl_a == chk_a_rx && fl_b == b && frm_class == CLASS_ACK &&
                        frm_payload[0] == want_class && frm_payload[1] == want_id) begin
                        outcome_q.push_back((frm_id == ID_ACK) ? OUT_ACK : OUT_NAK);
                        tick_cnt = '0;
                    end
                end
                default: begin
                    hunt_phase = (b == SYNC_CHAR_1) ? PH_SYNC2 : PH_SYNC1;
                end
            endcase
        end
    endtask

    // Monitor: report check first, so a report never meets its own cause's entry
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_xfer <= 1'b0;
        end else begin
            in_xfer <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (outcome_q.size() == 0) begin
                    flag_mismatch($sformatf("report 0x%02h with none pending", m_tdata));
                end else begin
                    head_outcome = outcome_q.pop_front();
                    if (m_tdata[1:0] != head_outcome)
                        flag_mismatch($sformatf("outcome %0d, predicted %s",
                                                m_tdata[1:0], head_outcome.name()));
                    if (m_tdata[7:2] != '0)
                        flag_mismatch($sformatf("tdata pad bits 0x%02h", m_tdata[7:2]));
                    case (head_outcome)
                        OUT_ACK: n_ack++;
                        OUT_NAK: n_nak++;
                        default: n_timeout++;
                    endcase
                end
            end
            if (s_tvalid && s_tready) begin
                predict_event(rx_event_t'{s_tuser[0], s_tdata});
                n_events++;
            end
        end
    end

    // Driver: bursts of transfers separated by random gaps
    int gap_left = 0;
    int burst_left = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_xfer) begin
            if (gap_left > 0 && !sender_steady) begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                next_ev = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_ev.action;
                s_tdata  <= next_ev.rx_byte;
                if (burst_left > 0) begin
                    burst_left = burst_left - 1;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: backpressure pattern switches at random among always ready, random and bursty modes
    rx_mode_t rx_mode = RX_ALWAYS;
    int rx_mode_left = 0;
    int stall_left = 0;
    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_t'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(50, 300);
        end else begin
            rx_mode_left = rx_mode_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS: m_tready <= 1'b1;
            RX_RANDOM: m_tready <= ($urandom_range(0, 2) != 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left = stall_left - 1;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
                end
            end
        endcase
    end

    // Watchdog
    always @(posedge aclk) begin
        cyc_count <= cyc_count + 1;
        if (cyc_count == CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", cyc_count);
            $display("FAIL ubx_ack_frame_parser");
            $finish;
        end
    end

    task automatic push_tick();
        pending_q.push_back(rx_event_t'{ACTION_TICK, 8'($urandom)});
        n_queued++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        if (tick_noise_pct > 0 && $urandom_range(0, 99) < tick_noise_pct) push_tick();
        pending_q.push_back(rx_event_t'{ACTION_BYTE, b});
        n_queued++;
    endtask

    // Full sync..checksum frame, optionally damaged in one place
    task automatic queue_frame(input logic [7:0] cls, input logic [7:0] id,
                               input logic [7:0] p0, input logic [7:0] p1,
                               input frame_flaw_t flaw);
        logic [7:0] body [6];
        logic [7:0] sum_lo;
        logic [7:0] sum_hi;
        logic [7:0] sync2;
        sum_lo  = '0;
        sum_hi  = '0;
        body[0] = cls;
        body[1] = id;
        body[2] = (flaw == FR_BAD_LEN_LO) ? 8'($urandom_range(3, 255)) : LEN_ACK_LO;
        body[3] = (flaw == FR_BAD_LEN_HI) ? 8'($urandom_range(1, 255)) : LEN_ACK_HI;
        body[4] = p0;
        body[5] = p1;
        foreach (body[k]) begin
            sum_lo = sum_lo + body[k];
            sum_hi = sum_hi + sum_lo;
        end
        if (flaw == FR_BAD_CK_A) sum_lo = sum_lo ^ 8'($urandom_range(1, 255));
        if (flaw == FR_BAD_CK_B) sum_hi = sum_hi ^ 8'($urandom_range(1, 255));
        sync2 = SYNC_CHAR_2;
        if (flaw == FR_BAD_SYNC2) begin
            sync2 = 8'($urandom);
            if (sync2 == SYNC_CHAR_2) sync2 = SYNC_CHAR_1;
        end
        push_byte(SYNC_CHAR_1);
        push_byte(sync2);
        foreach (body[k]) push_byte(body[k]);
        push_byte(sum_lo);
        push_byte(sum_hi);
    endtask

    // Mostly well-formed frames with random content, plus damage, noise and ticks
    task automatic queue_random_traffic(input int unsigned n);
        int unsigned stop_at;
        int          kind;
        logic [7:0]  id;
        logic [7:0]  p0;
        logic [7:0]  p1;
        stop_at = n_queued + n;
        while (n_queued < stop_at) begin
            kind = $urandom_range(0, 99);
            case ($urandom_range(0, 2))
                0:       id = ID_ACK;
                1:       id = ID_NAK_PLAIN;
                default: id = 8'($urandom);
            endcase
            p0 = ($urandom_range(0, 9) != 0) ? want_class : 8'($urandom);
            p1 = ($urandom_range(0, 9) != 0) ? want_id : 8'($urandom);
            if (kind < 60)
                queue_frame(CLASS_ACK, id, p0, p1, FR_GOOD);
            else if (kind < 68)
                queue_frame(8'($urandom), id, p0, p1, FR_GOOD);
            else if (kind < 80)
                queue_frame(CLASS_ACK, id, p0, p1, frame_flaw_t'($urandom_range(1, 5)));
            else if (kind < 90)
                repeat ($urandom_range(1, 4))
                    push_byte(($urandom_range(0, 3) == 0) ? SYNC_CHAR_1 : 8'($urandom));
            else
                repeat ($urandom_range(1, 6)) push_tick();
        end
    endtask

    // Register write through the config channel, mirrored into the shadow
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_EXP_CLASS: want_class = val[7:0];
            CFG_EXP_ID:    want_id    = val[7:0];
            CFG_TIMEOUT:   tick_limit = val;
            default: ;
        endcase
        n_cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Block until everything offered is accepted and every report is back
    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_q.size() != 0 || s_tvalid || outcome_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        frm_payload[0] = '0;
        frm_payload[1] = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: ACK, NAK, bad checksum, byte extremes, repeated first sync
        queue_frame(CLASS_ACK, ID_ACK, want_class, want_id, FR_GOOD);
        queue_frame(CLASS_ACK, ID_NAK_PLAIN, want_class, want_id, FR_GOOD);
        queue_frame(CLASS_ACK, ID_ACK, want_class, want_id, FR_BAD_CK_B);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(SYNC_CHAR_1);
        push_byte(SYNC_CHAR_1);
        push_byte(SYNC_CHAR_2);
        push_tick();
        wait_idle();

        // Low extremes; timeout 0 fires on every tick; spare index must be dropped
        set_reg(CFG_EXP_CLASS, {8'($urandom), 8'h00});
        set_reg(CFG_EXP_ID, {8'($urandom), 8'h00});
        set_reg(CFG_TIMEOUT, 16'd0);
        set_reg(CFG_SPARE, 16'hFFFF);
        push_tick();
        push_tick();
        queue_frame(CLASS_ACK, ID_ACK, 8'h00, 8'h00, FR_GOOD);
        queue_frame(CLASS_ACK, ID_ACK, 8'h00, 8'h00, FR_BAD_LEN_HI);
        queue_random_traffic(200);
        wait_idle();

        // High extremes, timeout 1
        set_reg(CFG_EXP_CLASS, 16'hFFFF);
        set_reg(CFG_EXP_ID, 16'hFFFF);
        set_reg(CFG_TIMEOUT, 16'd1);
        queue_frame(CLASS_ACK, ID_ACK, 8'hFF, 8'hFF, FR_GOOD);
        queue_random_traffic(200);
        wait_idle();

        // Random settings with short timeouts and ticks sprinkled into frames
        tick_noise_pct = 3;
        repeat (4) begin
            set_reg(CFG_EXP_CLASS, 16'($urandom));
            set_reg(CFG_EXP_ID, 16'($urandom));
            set_reg(CFG_TIMEOUT, 16'($urandom_range(2, 40)));
            queue_random_traffic(150);
            wait_idle();
        end

        // Longest timeout: traffic first, then a run of ticks without gaps
        set_reg(CFG_TIMEOUT, 16'hFFFF);
        queue_random_traffic(150);
        wait_idle();
        tick_noise_pct = 0;
        sender_steady  = 1'b1;
        repeat (100) push_tick();
        wait_idle();
        sender_steady  = 1'b0;

        // Back to the reset timeout
        tick_noise_pct = 3;
        set_reg(CFG_TIMEOUT, 16'd1000);
        queue_random_traffic(150);
        wait_idle();

        $display("Ran %0d events through %0d register writes",
                 n_events, n_cfg_writes);
        $display("across reset, extreme and random settings");
        $display("Reports checked: %0d ack, %0d nak, %0d timeout; mismatches: %0d",
                 n_ack, n_nak, n_timeout, n_errors);
        if (n_errors == 0 && outcome_q.size() == 0) begin
            $display("PASS ubx_ack_frame_parser");
        end else begin
            $display("FAIL ubx_ack_frame_parser");
        end
        $finish;
    end

endmodule
